// ===== sv/elastic_collision_normal_velocity_top_defines.svh =====
// Assertion macros for the elastic collision normal velocity block.
`ifndef ELASTIC_COLLISION_NORMAL_VELOCITY_TOP_DEFINES_SVH
`define ELASTIC_COLLISION_NORMAL_VELOCITY_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define ECNV_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ECNV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ECNV_ASSERT_IMPL(lbl, ante, cons, msg)
`define ECNV_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/ecnv_pkg.sv =====
// Types and constants shared by the elastic collision normal velocity block.
package ecnv_pkg;

  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned NrmNumW   = 62;
  localparam int unsigned NrmQuoW   = 31;
  localparam int unsigned ExchNumW  = 81;
  localparam int unsigned ExchQuoW  = 49;
  localparam int unsigned DenW      = 32;

  typedef struct packed {
    logic [31:0] vax;
    logic [31:0] vay;
    logic [31:0] vbx;
    logic [31:0] vby;
    logic [30:0] ma;
    logic [30:0] mb;
    logic        sx;
    logic        sy;
    logic        degen;
  } side_t;

  typedef struct packed {
    logic [30:0] ux;
    logic [30:0] uy;
    side_t       side;
  } sq_side_t;

  typedef struct packed {
    logic [47:0] pa;
    logic [47:0] pb;
    logic [31:0] nx;
    logic [31:0] ny;
    logic        dneg;
    logic        tzero;
    logic        degen;
  } exch_t;

  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] bx;
    logic [31:0] by;
    logic        degen;
  } result_t;

endpackage

// ===== sv/elastic_collision_normal_velocity_top.sv =====
// Top level of the two-body elastic collision normal velocity pipeline.
//
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o   | positions, velocities, masses
// out     | output    | out_valid_o/out_ready_i | new normal velocities, degenerate
//
// One item enters per cycle while in_ready_o is high.
// Most of the pipeline's depth lies in the 32-step square root and the 31- and 49-step dividers.
// Reset clears all valid bits; payload registers are not reset.
// A two-entry output buffer lets the pipeline keep moving while one result waits;
// the whole pipeline holds only when both entries are full.
`include "elastic_collision_normal_velocity_top_defines.svh"
module elastic_collision_normal_velocity_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] pos_a_x_i,
  input  logic [31:0] pos_a_y_i,
  input  logic [31:0] pos_b_x_i,
  input  logic [31:0] pos_b_y_i,
  input  logic [31:0] vel_a_x_i,
  input  logic [31:0] vel_a_y_i,
  input  logic [31:0] vel_b_x_i,
  input  logic [31:0] vel_b_y_i,
  input  logic [30:0] mass_a_i,
  input  logic [30:0] mass_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] new_vel_a_x_o,
  output logic [31:0] new_vel_a_y_o,
  output logic [31:0] new_vel_b_x_o,
  output logic [31:0] new_vel_b_y_o,
  output logic        degenerate_o
);

  function automatic logic [31:0] sat32(input logic neg, input logic [35:0] m);
    logic [35:0] mm;
    begin
      if (neg) begin
        mm = (m > 36'h080000000) ? 36'h080000000 : m;
        mm = 36'd0 - mm;
        sat32 = mm[31:0];
      end else begin
        sat32 = (m > 36'h07FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
      end
    end
  endfunction

  logic en;
  logic push, pop;

  // Front end: center difference, magnitudes, normalization, squares.
  logic [4:0]         fv_q;
  logic [32:0]        dx0_q, dy0_q;
  ecnv_pkg::side_t    side0_q, side1_q, side2_q, side3_q, side4_q;
  logic [32:0]        ux1_q, uy1_q, ux2_q, uy2_q;
  logic [32:0]        mor;
  logic [5:0]         pos2_d, pos2_q;
  logic [32:0]        ux3_d, uy3_d;
  logic [30:0]        ux3_q, uy3_q, ux4_q, uy4_q;
  logic [61:0]        sqx4_q, sqy4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (en) begin
      fv_q <= {fv_q[3:0], in_valid_i};
    end
  end

  always_comb begin
    mor    = ux1_q | uy1_q;
    pos2_d = '0;
    for (int i = 0; i < 33; i++) begin
      if (mor[i]) begin
        pos2_d = 6'(i);
      end
    end
  end

  always_comb begin
    if (pos2_q > 6'd30) begin
      ux3_d = ux2_q >> (pos2_q - 6'd30);
      uy3_d = uy2_q >> (pos2_q - 6'd30);
    end else begin
      ux3_d = ux2_q << (6'd30 - pos2_q);
      uy3_d = uy2_q << (6'd30 - pos2_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx0_q         <= {pos_a_x_i[31], pos_a_x_i} - {pos_b_x_i[31], pos_b_x_i};
      dy0_q         <= {pos_a_y_i[31], pos_a_y_i} - {pos_b_y_i[31], pos_b_y_i};
      side0_q.vax   <= vel_a_x_i;
      side0_q.vay   <= vel_a_y_i;
      side0_q.vbx   <= vel_b_x_i;
      side0_q.vby   <= vel_b_y_i;
      side0_q.ma    <= mass_a_i;
      side0_q.mb    <= mass_b_i;
      side0_q.sx    <= 1'b0;
      side0_q.sy    <= 1'b0;
      side0_q.degen <= 1'b0;

      ux1_q         <= dx0_q[32] ? (33'd0 - dx0_q) : dx0_q;
      uy1_q         <= dy0_q[32] ? (33'd0 - dy0_q) : dy0_q;
      side1_q.vax   <= side0_q.vax;
      side1_q.vay   <= side0_q.vay;
      side1_q.vbx   <= side0_q.vbx;
      side1_q.vby   <= side0_q.vby;
      side1_q.ma    <= side0_q.ma;
      side1_q.mb    <= side0_q.mb;
      side1_q.sx    <= dx0_q[32];
      side1_q.sy    <= dy0_q[32];
      side1_q.degen <= (dx0_q == 33'd0) && (dy0_q == 33'd0);

      ux2_q   <= ux1_q;
      uy2_q   <= uy1_q;
      pos2_q  <= pos2_d;
      side2_q <= side1_q;

      ux3_q   <= ux3_d[30:0];
      uy3_q   <= uy3_d[30:0];
      side3_q <= side2_q;

      sqx4_q  <= ux3_q * ux3_q;
      sqy4_q  <= uy3_q * uy3_q;
      ux4_q   <= ux3_q;
      uy4_q   <= uy3_q;
      side4_q <= side3_q;
    end
  end

  // Square root, two radicand bits per stage.
  logic [ecnv_pkg::SqrtSteps:0] sv_q;
  logic [63:0]        sbits_q [ecnv_pkg::SqrtSteps];
  logic [33:0]        srem_q  [ecnv_pkg::SqrtSteps];
  logic [31:0]        sroot_q [ecnv_pkg::SqrtSteps+1];
  ecnv_pkg::sq_side_t ssd_q   [ecnv_pkg::SqrtSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (en) begin
      sv_q[0] <= fv_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sbits_q[0]     <= 64'(sqx4_q) + 64'(sqy4_q);
      srem_q[0]      <= '0;
      sroot_q[0]     <= '0;
      ssd_q[0].ux    <= ux4_q;
      ssd_q[0].uy    <= uy4_q;
      ssd_q[0].side  <= side4_q;
    end
  end

  for (genvar k = 1; k <= ecnv_pkg::SqrtSteps; k++) begin : g_sqrt
    logic [35:0] remx, trial, sub;
    logic        ge;

    always_comb begin
      remx  = {srem_q[k-1], sbits_q[k-1][63:62]};
      trial = {2'b00, sroot_q[k-1], 2'b01};
      sub   = remx - trial;
      ge    = remx >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k] <= 1'b0;
      end else if (en) begin
        sv_q[k] <= sv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sroot_q[k] <= {sroot_q[k-1][30:0], ge};
        ssd_q[k]   <= ssd_q[k-1];
      end
    end

    if (k < ecnv_pkg::SqrtSteps) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en) begin
          srem_q[k]  <= ge ? sub[33:0] : remx[33:0];
          sbits_q[k] <= {sbits_q[k-1][61:0], 2'b00};
        end
      end
    end
  end

  // Unit normal: round(u * 2^30 / len) for both components.
  logic [31:0]                   len;
  logic [ecnv_pkg::NrmNumW-1:0]  nnum_x, nnum_y;
  logic                          d1_vld;
  logic [ecnv_pkg::NrmQuoW-1:0]  d1_qx, d1_qy;
  logic [$bits(ecnv_pkg::side_t)-1:0] d1_tag;
  ecnv_pkg::side_t               d1_side;

  assign len    = sroot_q[ecnv_pkg::SqrtSteps];
  assign nnum_x = (62'(ssd_q[ecnv_pkg::SqrtSteps].ux) << 30) + 62'(len[31:1]);
  assign nnum_y = (62'(ssd_q[ecnv_pkg::SqrtSteps].uy) << 30) + 62'(len[31:1]);

  ecnv_div #(
    .NUM_W (ecnv_pkg::NrmNumW),
    .DEN_W (ecnv_pkg::DenW),
    .QUO_W (ecnv_pkg::NrmQuoW),
    .TAG_W ($bits(ecnv_pkg::side_t))
  ) u_div_nrm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sv_q[ecnv_pkg::SqrtSteps]),
    .num0_i  (nnum_x),
    .num1_i  (nnum_y),
    .den_i   (len),
    .tag_i   (ssd_q[ecnv_pkg::SqrtSteps].side),
    .valid_o (d1_vld),
    .quo0_o  (d1_qx),
    .quo1_o  (d1_qy),
    .tag_o   (d1_tag)
  );

  assign d1_side = d1_tag;

  // Projection and exchange setup.
  logic [6:0]         pv_q;
  logic [31:0]        nx0_q, ny0_q;
  ecnv_pkg::side_t    side5_q;
  logic signed [63:0] pr_ax1_q, pr_ay1_q, pr_bx1_q, pr_by1_q;
  logic [31:0]        nx1_q, ny1_q, nx2_q, ny2_q, nx3_q, ny3_q, nx4_q, ny4_q;
  logic [30:0]        ma1_q, mb1_q, ma2_q, mb2_q, ma3_q, mb3_q, ma4_q, mb4_q;
  logic [30:0]        ma5_q, mb5_q;
  logic               dg1_q, dg2_q, dg3_q, dg4_q;
  logic [64:0]        sa2_q, sb2_q;
  logic [64:0]        pam, pbm;
  logic [63:0]        par, pbr;
  logic [47:0]        pa3_q, pb3_q, pa4_q, pb4_q;
  logic [48:0]        diff4_q, xabs;
  logic [31:0]        tot4_q, tot5_q, tot6_q;
  logic [47:0]        xm5_q;
  ecnv_pkg::exch_t    ex5_q, ex6_q;
  logic [55:0]        lo_a6_q, hi_a6_q, lo_b6_q, hi_b6_q;

  always_comb begin
    pam  = sa2_q[64] ? (65'd0 - sa2_q) : sa2_q;
    pbm  = sb2_q[64] ? (65'd0 - sb2_q) : sb2_q;
    par  = pam[63:0] + 64'd32768;
    pbr  = pbm[63:0] + 64'd32768;
    xabs = diff4_q[48] ? (49'd0 - diff4_q) : diff4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (en) begin
      pv_q <= {pv_q[5:0], d1_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx0_q   <= d1_side.sx ? (32'd0 - {1'b0, d1_qx}) : {1'b0, d1_qx};
      ny0_q   <= d1_side.sy ? (32'd0 - {1'b0, d1_qy}) : {1'b0, d1_qy};
      side5_q <= d1_side;

      pr_ax1_q <= $signed(side5_q.vax) * $signed(nx0_q);
      pr_ay1_q <= $signed(side5_q.vay) * $signed(ny0_q);
      pr_bx1_q <= $signed(side5_q.vbx) * $signed(nx0_q);
      pr_by1_q <= $signed(side5_q.vby) * $signed(ny0_q);
      nx1_q    <= nx0_q;
      ny1_q    <= ny0_q;
      ma1_q    <= side5_q.ma;
      mb1_q    <= side5_q.mb;
      dg1_q    <= side5_q.degen;

      sa2_q <= {pr_ax1_q[63], pr_ax1_q} + {pr_ay1_q[63], pr_ay1_q};
      sb2_q <= {pr_bx1_q[63], pr_bx1_q} + {pr_by1_q[63], pr_by1_q};
      nx2_q <= nx1_q;
      ny2_q <= ny1_q;
      ma2_q <= ma1_q;
      mb2_q <= mb1_q;
      dg2_q <= dg1_q;

      pa3_q <= sa2_q[64] ? (48'd0 - par[63:16]) : par[63:16];
      pb3_q <= sb2_q[64] ? (48'd0 - pbr[63:16]) : pbr[63:16];
      nx3_q <= nx2_q;
      ny3_q <= ny2_q;
      ma3_q <= ma2_q;
      mb3_q <= mb2_q;
      dg3_q <= dg2_q;

      diff4_q <= {pa3_q[47], pa3_q} - {pb3_q[47], pb3_q};
      tot4_q  <= {1'b0, ma3_q} + {1'b0, mb3_q};
      pa4_q   <= pa3_q;
      pb4_q   <= pb3_q;
      nx4_q   <= nx3_q;
      ny4_q   <= ny3_q;
      ma4_q   <= ma3_q;
      mb4_q   <= mb3_q;
      dg4_q   <= dg3_q;

      xm5_q       <= xabs[47:0];
      tot5_q      <= tot4_q;
      ma5_q       <= ma4_q;
      mb5_q       <= mb4_q;
      ex5_q.pa    <= pa4_q;
      ex5_q.pb    <= pb4_q;
      ex5_q.nx    <= nx4_q;
      ex5_q.ny    <= ny4_q;
      ex5_q.dneg  <= diff4_q[48];
      ex5_q.tzero <= (tot4_q == 32'd0);
      ex5_q.degen <= dg4_q;

      lo_a6_q <= xm5_q[23:0] * {mb5_q, 1'b0};
      hi_a6_q <= xm5_q[47:24] * {mb5_q, 1'b0};
      lo_b6_q <= xm5_q[23:0] * {ma5_q, 1'b0};
      hi_b6_q <= xm5_q[47:24] * {ma5_q, 1'b0};
      tot6_q  <= tot5_q;
      ex6_q   <= ex5_q;
    end
  end

  // Exchange impulse: round(|diff| * 2m / (mA + mB)) for both bodies.
  logic [ecnv_pkg::ExchNumW-1:0] enum_a, enum_b;
  logic                          d2_vld;
  logic [ecnv_pkg::ExchQuoW-1:0] d2_ja, d2_jb;
  logic [$bits(ecnv_pkg::exch_t)-1:0] d2_tag;
  ecnv_pkg::exch_t               d2_ex;

  assign enum_a = {1'b0, hi_a6_q, 24'd0} + {25'd0, lo_a6_q} + {50'd0, tot6_q[31:1]};
  assign enum_b = {1'b0, hi_b6_q, 24'd0} + {25'd0, lo_b6_q} + {50'd0, tot6_q[31:1]};

  ecnv_div #(
    .NUM_W (ecnv_pkg::ExchNumW),
    .DEN_W (ecnv_pkg::DenW),
    .QUO_W (ecnv_pkg::ExchQuoW),
    .TAG_W ($bits(ecnv_pkg::exch_t))
  ) u_div_exch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pv_q[6]),
    .num0_i  (enum_a),
    .num1_i  (enum_b),
    .den_i   (tot6_q),
    .tag_i   (ex6_q),
    .valid_o (d2_vld),
    .quo0_o  (d2_ja),
    .quo1_o  (d2_jb),
    .tag_o   (d2_tag)
  );

  assign d2_ex = d2_tag;

  // Output scaling: round(|u| * |n| / 2^44) with saturation.
  logic [3:0]  qv_q;
  logic [49:0] jsa, jsb, pa_x, pb_x, ua_d, ub_d;
  logic [49:0] ua0_q, ub0_q, uam, ubm;
  logic [31:0] nx0b_q, ny0b_q, nxm, nym;
  logic        dg5_q, dg6_q, dg7_q, dg8_q;
  logic [48:0] uam1_q, ubm1_q;
  logic [30:0] nxm1_q, nym1_q;
  logic [3:0]  ng1_q, ng2_q, ng3_q;
  logic [55:0] ax_lo_q, ay_lo_q, bx_lo_q, by_lo_q;
  logic [54:0] ax_hi_q, ay_hi_q, bx_hi_q, by_hi_q;
  logic [79:0] ax_s, ay_s, bx_s, by_s;
  logic [35:0] ax3_q, ay3_q, bx3_q, by3_q;
  ecnv_pkg::result_t res_d;

  always_comb begin
    jsa  = d2_ex.dneg ? (50'd0 - {1'b0, d2_ja}) : {1'b0, d2_ja};
    jsb  = d2_ex.dneg ? (50'd0 - {1'b0, d2_jb}) : {1'b0, d2_jb};
    pa_x = {{2{d2_ex.pa[47]}}, d2_ex.pa};
    pb_x = {{2{d2_ex.pb[47]}}, d2_ex.pb};
    ua_d = d2_ex.tzero ? pa_x : (pa_x - jsa);
    ub_d = d2_ex.tzero ? pb_x : (pb_x + jsb);
    uam  = ua0_q[49] ? (50'd0 - ua0_q) : ua0_q;
    ubm  = ub0_q[49] ? (50'd0 - ub0_q) : ub0_q;
    nxm  = nx0b_q[31] ? (32'd0 - nx0b_q) : nx0b_q;
    nym  = ny0b_q[31] ? (32'd0 - ny0b_q) : ny0b_q;
    ax_s = {ax_hi_q, 25'd0} + {24'd0, ax_lo_q} + 80'h80000000000;
    ay_s = {ay_hi_q, 25'd0} + {24'd0, ay_lo_q} + 80'h80000000000;
    bx_s = {bx_hi_q, 25'd0} + {24'd0, bx_lo_q} + 80'h80000000000;
    by_s = {by_hi_q, 25'd0} + {24'd0, by_lo_q} + 80'h80000000000;
    res_d.degen = dg8_q;
    if (dg8_q) begin
      res_d.ax = '0;
      res_d.ay = '0;
      res_d.bx = '0;
      res_d.by = '0;
    end else begin
      res_d.ax = sat32(ng3_q[3], ax3_q);
      res_d.ay = sat32(ng3_q[2], ay3_q);
      res_d.bx = sat32(ng3_q[1], bx3_q);
      res_d.by = sat32(ng3_q[0], by3_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qv_q <= '0;
    end else if (en) begin
      qv_q <= {qv_q[2:0], d2_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ua0_q  <= ua_d;
      ub0_q  <= ub_d;
      nx0b_q <= d2_ex.nx;
      ny0b_q <= d2_ex.ny;
      dg5_q  <= d2_ex.degen;

      uam1_q <= uam[48:0];
      ubm1_q <= ubm[48:0];
      nxm1_q <= nxm[30:0];
      nym1_q <= nym[30:0];
      ng1_q  <= {ua0_q[49] ^ nx0b_q[31], ua0_q[49] ^ ny0b_q[31],
                 ub0_q[49] ^ nx0b_q[31], ub0_q[49] ^ ny0b_q[31]};
      dg6_q  <= dg5_q;

      ax_lo_q <= uam1_q[24:0] * nxm1_q;
      ax_hi_q <= uam1_q[48:25] * nxm1_q;
      ay_lo_q <= uam1_q[24:0] * nym1_q;
      ay_hi_q <= uam1_q[48:25] * nym1_q;
      bx_lo_q <= ubm1_q[24:0] * nxm1_q;
      bx_hi_q <= ubm1_q[48:25] * nxm1_q;
      by_lo_q <= ubm1_q[24:0] * nym1_q;
      by_hi_q <= ubm1_q[48:25] * nym1_q;
      ng2_q   <= ng1_q;
      dg7_q   <= dg6_q;

      ax3_q <= ax_s[79:44];
      ay3_q <= ay_s[79:44];
      bx3_q <= bx_s[79:44];
      by3_q <= by_s[79:44];
      ng3_q <= ng2_q;
      dg8_q <= dg7_q;
    end
  end

  // Two-entry output buffer.
  ecnv_pkg::result_t hd_q, hd_d, sk_q, sk_d;
  logic              hd_vld_q, hd_vld_d, sk_vld_q, sk_vld_d;

  assign en   = !(hd_vld_q && sk_vld_q);
  assign push = en && qv_q[3];
  assign pop  = hd_vld_q && out_ready_i;

  always_comb begin
    hd_d     = hd_q;
    sk_d     = sk_q;
    hd_vld_d = hd_vld_q;
    sk_vld_d = sk_vld_q;
    if (pop) begin
      if (sk_vld_q) begin
        hd_d     = sk_q;
        sk_vld_d = 1'b0;
      end else begin
        hd_vld_d = 1'b0;
      end
    end
    if (push) begin
      if (!hd_vld_d) begin
        hd_d     = res_d;
        hd_vld_d = 1'b1;
      end else begin
        sk_d     = res_d;
        sk_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hd_vld_q <= 1'b0;
      sk_vld_q <= 1'b0;
    end else begin
      hd_vld_q <= hd_vld_d;
      sk_vld_q <= sk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hd_q <= hd_d;
    sk_q <= sk_d;
  end

  assign in_ready_o    = en;
  assign out_valid_o   = hd_vld_q;
  assign new_vel_a_x_o = hd_q.ax;
  assign new_vel_a_y_o = hd_q.ay;
  assign new_vel_b_x_o = hd_q.bx;
  assign new_vel_b_y_o = hd_q.by;
  assign degenerate_o  = hd_q.degen;

  `ECNV_ASSERT_IMPL(a_degen_zero, out_valid_o && degenerate_o, new_vel_a_x_o == 32'd0 && new_vel_a_y_o == 32'd0 && new_vel_b_x_o == 32'd0 && new_vel_b_y_o == 32'd0, "degenerate result carries nonzero velocity")
  `ECNV_ASSERT_IMPL(a_skid_order, sk_vld_q, hd_vld_q, "skid entry held while head entry empty")
  `ECNV_ASSERT_NEXT(a_full_hold, !in_ready_o && !out_ready_i, !in_ready_o, "full buffer drained without a transfer")

endmodule

// ===== sv/ecnv_div.sv =====
// Pipelined restoring divider: two numerators over one shared denominator.
module ecnv_div #(
  parameter int unsigned NUM_W = 62,
  parameter int unsigned DEN_W = 32,
  parameter int unsigned QUO_W = 31,
  parameter int unsigned TAG_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num0_i,
  input  logic [NUM_W-1:0] num1_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] quo0_o,
  output logic [QUO_W-1:0] quo1_o,
  output logic [TAG_W-1:0] tag_o
);

  logic [QUO_W:0]   vld_q;
  logic [QUO_W-1:0] quo0_q [QUO_W+1];
  logic [QUO_W-1:0] quo1_q [QUO_W+1];
  logic [TAG_W-1:0] tag_q  [QUO_W+1];
  logic [DEN_W-1:0] rem0_q [QUO_W];
  logic [DEN_W-1:0] rem1_q [QUO_W];
  logic [QUO_W-1:0] low0_q [QUO_W];
  logic [QUO_W-1:0] low1_q [QUO_W];
  logic [DEN_W-1:0] den_q  [QUO_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem0_q[0] <= DEN_W'(num0_i[NUM_W-1:QUO_W]);
      rem1_q[0] <= DEN_W'(num1_i[NUM_W-1:QUO_W]);
      low0_q[0] <= num0_i[QUO_W-1:0];
      low1_q[0] <= num1_i[QUO_W-1:0];
      quo0_q[0] <= '0;
      quo1_q[0] <= '0;
      den_q[0]  <= den_i;
      tag_q[0]  <= tag_i;
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
    logic [DEN_W:0] trial0, trial1, diff0, diff1;
    logic           ge0, ge1;

    always_comb begin
      trial0 = {rem0_q[k-1], low0_q[k-1][QUO_W-1]};
      trial1 = {rem1_q[k-1], low1_q[k-1][QUO_W-1]};
      diff0  = trial0 - {1'b0, den_q[k-1]};
      diff1  = trial1 - {1'b0, den_q[k-1]};
      ge0    = trial0 >= {1'b0, den_q[k-1]};
      ge1    = trial1 >= {1'b0, den_q[k-1]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo0_q[k] <= {quo0_q[k-1][QUO_W-2:0], ge0};
        quo1_q[k] <= {quo1_q[k-1][QUO_W-2:0], ge1};
        tag_q[k]  <= tag_q[k-1];
      end
    end

    if (k < QUO_W) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem0_q[k] <= ge0 ? diff0[DEN_W-1:0] : trial0[DEN_W-1:0];
          rem1_q[k] <= ge1 ? diff1[DEN_W-1:0] : trial1[DEN_W-1:0];
          low0_q[k] <= {low0_q[k-1][QUO_W-2:0], 1'b0};
          low1_q[k] <= {low1_q[k-1][QUO_W-2:0], 1'b0};
          den_q[k]  <= den_q[k-1];
        end
      end
    end
  end

  assign valid_o = vld_q[QUO_W];
  assign quo0_o  = quo0_q[QUO_W];
  assign quo1_o  = quo1_q[QUO_W];
  assign tag_o   = tag_q[QUO_W];

endmodule
